@@ rtl/bmas_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmas_pkg
// Shared sizes and types of the 2D autocorrelation sidelobe histogram.
// ----------------------------------------------------------------------------
package bmas_pkg;

	localparam int ROWS          = 5;
	localparam int COLS          = 5;
	localparam int SPECTRUM_BINS = 20;
	localparam int MAX_RESULTS   = 20;

	localparam int MATRIX_W = 25;
	localparam int INDEX_W  = 5;
	localparam int COUNT_W  = 7;
	localparam int PEAK_W   = 5;

	localparam int NCELL = ROWS * COLS;
	localparam int EXT_W = (NCELL > MATRIX_W) ? NCELL : MATRIX_W;
	localparam int GRP   = 2 * ROWS - 1;
	localparam int GSIZE = 2 * COLS - 1;
	localparam int NLAG  = GRP * GSIZE;
	localparam int CW    = $clog2(COLS + 1);
	localparam int OVW   = $clog2(NCELL + 1);
	localparam int GW    = $clog2(GSIZE + 1);
	localparam int HW    = $clog2(NLAG + 1);
	localparam int SW    = (SPECTRUM_BINS > 1) ? $clog2(SPECTRUM_BINS) : 1;
	localparam int N_OUT = (SPECTRUM_BINS < MAX_RESULTS) ? SPECTRUM_BINS : MAX_RESULTS;
	localparam int BW    = (N_OUT > 1) ? $clog2(N_OUT) : 1;

	localparam int COUNT_MAX = (1 << COUNT_W) - 1;
	localparam int PEAK_MAX  = (1 << PEAK_W) - 1;

	typedef logic [NLAG-1:0][OVW-1:0]         lag_vec_t;
	typedef logic [SPECTRUM_BINS-1:0][HW-1:0] hist_vec_t;

	typedef struct packed {
		logic            valid;
		lag_vec_t        lags;
		logic [OVW-1:0]  ones;
	} lag_word_t;

	typedef struct packed {
		logic            valid;
		hist_vec_t       hist;
		logic [OVW-1:0]  ones;
		logic [SW-1:0]   side;
	} hist_word_t;

endpackage

@@ rtl/bmas_corr.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmas_corr
// Four-stage pipeline giving the overlap count of every 2D shift and the
// number of ones of the matrix.
// ----------------------------------------------------------------------------
module bmas_corr
	import bmas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [MATRIX_W-1:0] matrix_bits,
	output lag_word_t           lag_out
);

	logic                              v_s1, v_s2, v_s3, v_s4;
	logic [NCELL-1:0]                  m_s1, m_s2;
	logic [NLAG-1:0][NCELL-1:0]        and_d, and_s2;
	logic [NLAG-1:0][ROWS-1:0][CW-1:0] rc_d, rc_s3;
	logic [ROWS-1:0][CW-1:0]           orc_d, orc_s3;
	lag_vec_t                          lag_d, lag_s4;
	logic [OVW-1:0]                    ones_d, ones_s4;
	logic [EXT_W-1:0]                  m_ext;

	assign m_ext = EXT_W'(matrix_bits);

	// shifted overlap masks
	always_comb begin
		int dr, dc, sr, sc, idx;
		and_d = '0;
		for (int a = 0; a < GRP; a++) begin
			for (int b = 0; b < GSIZE; b++) begin
				dr  = a - (ROWS - 1);
				dc  = b - (COLS - 1);
				idx = a * GSIZE + b;
				for (int r = 0; r < ROWS; r++) begin
					for (int c = 0; c < COLS; c++) begin
						sr = r - dr;
						sc = c - dc;
						if (sr >= 0 && sr < ROWS && sc >= 0 && sc < COLS)
							and_d[idx][r*COLS+c] = m_s1[r*COLS+c] & m_s1[sr*COLS+sc];
					end
				end
			end
		end
	end

	// per-row partial counts
	always_comb begin
		rc_d  = '0;
		orc_d = '0;
		for (int i = 0; i < NLAG; i++)
			for (int r = 0; r < ROWS; r++)
				for (int c = 0; c < COLS; c++)
					rc_d[i][r] = rc_d[i][r] + CW'(and_s2[i][r*COLS+c]);
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				orc_d[r] = orc_d[r] + CW'(m_s2[r*COLS+c]);
	end

	// row sums
	always_comb begin
		lag_d  = '0;
		ones_d = '0;
		for (int i = 0; i < NLAG; i++)
			for (int r = 0; r < ROWS; r++)
				lag_d[i] = lag_d[i] + OVW'(rc_s3[i][r]);
		for (int r = 0; r < ROWS; r++)
			ones_d = ones_d + OVW'(orc_s3[r]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= load;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		m_s1    <= m_ext[NCELL-1:0];
		m_s2    <= m_s1;
		and_s2  <= and_d;
		rc_s3   <= rc_d;
		orc_s3  <= orc_d;
		lag_s4  <= lag_d;
		ones_s4 <= ones_d;
	end

	assign lag_out.valid = v_s4;
	assign lag_out.lags  = lag_s4;
	assign lag_out.ones  = ones_s4;

endmodule

@@ rtl/bmas_hist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmas_hist
// Three-stage histogram of the off-peak overlap values and peak sidelobe
// search.
// ----------------------------------------------------------------------------
module bmas_hist
	import bmas_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  lag_word_t  lag_in,
	output hist_word_t hist_out
);

	logic                                     v_s5, v_s6, v_s7;
	logic [SPECTRUM_BINS-1:0][GRP-1:0][GW-1:0] grp_d, grp_s5;
	hist_vec_t                                hist_d, hist_s6, hist_s7;
	logic [OVW-1:0]                           ones_s5, ones_s6, ones_s7;
	logic [SW-1:0]                            side_d, side_s7;

	// counts per bin within each row of shifts
	always_comb begin
		grp_d = '0;
		for (int k = 0; k < SPECTRUM_BINS; k++)
			for (int a = 0; a < GRP; a++)
				for (int b = 0; b < GSIZE; b++)
					if (int'(lag_in.lags[a*GSIZE+b]) == k && lag_in.lags[a*GSIZE+b] < lag_in.ones)
						grp_d[k][a] = grp_d[k][a] + GW'(1);
	end

	always_comb begin
		hist_d = '0;
		for (int k = 0; k < SPECTRUM_BINS; k++)
			for (int a = 0; a < GRP; a++)
				hist_d[k] = hist_d[k] + HW'(grp_s5[k][a]);
	end

	// highest occupied bin
	always_comb begin
		side_d = '0;
		for (int k = 1; k < SPECTRUM_BINS; k++)
			if (hist_s6[k] != '0)
				side_d = SW'(k);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s5 <= lag_in.valid;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		grp_s5  <= grp_d;
		ones_s5 <= lag_in.ones;
		hist_s6 <= hist_d;
		ones_s6 <= ones_s5;
		hist_s7 <= hist_s6;
		ones_s7 <= ones_s6;
		side_s7 <= side_d;
	end

	assign hist_out.valid = v_s7;
	assign hist_out.hist  = hist_s7;
	assign hist_out.ones  = ones_s7;
	assign hist_out.side  = side_s7;

endmodule

@@ rtl/bmas_ser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmas_ser
// Holding slot and bin serialiser; tracks matrices in flight and drives busy.
// ----------------------------------------------------------------------------
module bmas_ser
	import bmas_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  hist_word_t         hist_in,
	output logic               busy,
	output logic               strobe,
	output logic [INDEX_W-1:0] bin_index,
	output logic [COUNT_W-1:0] bin_count,
	output logic [PEAK_W-1:0]  peak_value,
	output logic [PEAK_W-1:0]  peak_sidelobe,
	output logic               last_bin
);

	logic                           act_q, hold_v_q;
	logic [1:0]                     cnt_q;
	logic [BW-1:0]                  bin_q;
	hist_word_t                     hold_q, src;
	logic [N_OUT-1:0][COUNT_W-1:0]  sh_q;
	logic [PEAK_W-1:0]              peak_q, side_q;
	logic                           fin, can_load, take_hold, take_in, to_hold;

	assign fin       = act_q && (bin_q == BW'(N_OUT - 1));
	assign can_load  = !act_q || fin;
	assign take_hold = can_load && hold_v_q;
	assign take_in   = can_load && !hold_v_q && hist_in.valid;
	assign to_hold   = hist_in.valid && !take_in;
	assign src       = hold_v_q ? hold_q : hist_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			hold_v_q <= 1'b0;
			cnt_q    <= '0;
			bin_q    <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(load) - 2'(fin);
			if (to_hold)
				hold_v_q <= 1'b1;
			else if (take_hold)
				hold_v_q <= 1'b0;
			if (can_load) begin
				act_q <= take_hold || take_in;
				bin_q <= '0;
			end else begin
				bin_q <= bin_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (to_hold)
			hold_q <= hist_in;
		if (can_load) begin
			for (int k = 0; k < N_OUT; k++)
				sh_q[k] <= (src.hist[k] > COUNT_MAX) ? COUNT_W'(COUNT_MAX) :
					COUNT_W'(src.hist[k]);
			peak_q <= (src.ones > PEAK_MAX) ? PEAK_W'(PEAK_MAX) : PEAK_W'(src.ones);
			side_q <= (src.side > PEAK_MAX) ? PEAK_W'(PEAK_MAX) : PEAK_W'(src.side);
		end else begin
			for (int k = 0; k < N_OUT - 1; k++)
				sh_q[k] <= sh_q[k+1];
		end
	end

	assign busy          = (cnt_q == 2'd2);
	assign strobe        = act_q;
	assign bin_index     = INDEX_W'(bin_q);
	assign bin_count     = sh_q[0];
	assign peak_value    = peak_q;
	assign peak_sidelobe = side_q;
	assign last_bin      = fin;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("more than two matrices in flight");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		hist_in.valid |-> !(hold_v_q && !can_load))
		else $error("histogram word arrived with holding slot full");

	a_next_start: assert property (@(posedge clk) disable iff (!arst_n)
		last_bin |=> (!strobe || bin_index == '0))
		else $error("new matrix did not start at bin zero");

	a_active_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> cnt_q != 2'd0)
		else $error("bins emitted with no matrix in flight");

endmodule

@@ rtl/binary_matrix_autocorrelation_spectrum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_matrix_autocorrelation_spectrum
// 2D aperiodic autocorrelation of a binary matrix, reported as a histogram
// of off-peak overlap values with peak and peak sidelobe.
//
// A matrix word is taken on matrix_bits at a rising edge with start high
// and busy low. For each matrix the block emits N_OUT result words, one per
// cycle in bin order, each marked by strobe for a single cycle; last_bin
// flags the final one. The receiver cannot stall and the block never holds
// a result back.
// The first bin follows the accepting edge through the 4 correlation stages,
// the 3 histogram stages and the serialiser load, and may wait in the holding
// slot while an earlier matrix is serialised.
// The serialiser sends one bin a cycle. Up to two matrices are in flight
// between their accepting edge and their last bin, the later one possibly
// waiting in the holding slot while the other is serialised; busy is high
// while two are in flight.
// Reset clears all valid bits, the holding slot and the in-flight count;
// the block is ready at once with no outputs pending.
// ----------------------------------------------------------------------------
module binary_matrix_autocorrelation_spectrum
	import bmas_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MATRIX_W-1:0] matrix_bits,
	output logic                strobe,
	output logic [INDEX_W-1:0]  bin_index,
	output logic [COUNT_W-1:0]  bin_count,
	output logic [PEAK_W-1:0]   peak_value,
	output logic [PEAK_W-1:0]   peak_sidelobe,
	output logic                last_bin
);

	logic       load;
	lag_word_t  lag_w;
	hist_word_t hist_w;

	assign load = start && !busy;

	bmas_corr u_corr (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.matrix_bits (matrix_bits),
		.lag_out     (lag_w)
	);

	bmas_hist u_hist (
		.clk      (clk),
		.arst_n   (arst_n),
		.lag_in   (lag_w),
		.hist_out (hist_w)
	);

	bmas_ser u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.hist_in       (hist_w),
		.busy          (busy),
		.strobe        (strobe),
		.bin_index     (bin_index),
		.bin_count     (bin_count),
		.peak_value    (peak_value),
		.peak_sidelobe (peak_sidelobe),
		.last_bin      (last_bin)
	);

endmodule
